>>> src/bvg_pkg.sv
// Package: constants, discharge curve, microcode types for the battery voltage gauge.
package bvg_pkg;

  localparam int SAMPLES_PER_UPDATE = 8;
  localparam int ADC_BITS           = 12;

  localparam int PIN_FULL_MV = 3100;
  localparam int SCALE_W     = 12;
  localparam int ADC_FULL    = (1 << ADC_BITS) - 1;
  localparam int PIN_MV_W    = (ADC_BITS > SCALE_W) ? ADC_BITS : SCALE_W;
  localparam int PROD_W      = ADC_BITS + SCALE_W;
  localparam int QE_W        = SCALE_W + 1;

  localparam int CNT_W       = $clog2(SAMPLES_PER_UPDATE + 1);
  localparam int SUM_W       = PIN_MV_W + CNT_W;
  localparam int DEN_W       = 9;
  localparam int DIV_STEP_W  = $clog2(SUM_W + 1);

  localparam int RATIO_W     = 3;
  localparam int MV_W        = 14;
  localparam int MV_MAX      = (1 << MV_W) - 1;
  localparam int MEAS_W      = SUM_W + RATIO_W;
  localparam int PCT_W       = 7;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = RATIO_W;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_RATIO = CFG_IDX_W'(1);
  localparam logic [RATIO_W-1:0]   RATIO_RESET       = RATIO_W'(2);

  localparam int CURVE_POINTS = 13;
  localparam int SEG_W        = 4;

  typedef logic [MV_W-1:0]  mv_t;
  typedef logic [PCT_W-1:0] pct_t;

  localparam mv_t CURVE_MV [CURVE_POINTS] = '{
    14'd4200, 14'd4100, 14'd4000, 14'd3900, 14'd3800, 14'd3750, 14'd3700,
    14'd3650, 14'd3600, 14'd3500, 14'd3400, 14'd3300, 14'd3000
  };
  localparam pct_t CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd92, 7'd84, 7'd74, 7'd62, 7'd54, 7'd44,
    7'd32, 7'd22, 7'd12, 7'd6, 7'd2, 7'd0
  };

  function automatic mv_t curve_mv(input logic [SEG_W-1:0] idx);
    mv_t v;
    v = '0;
    if (idx < SEG_W'(CURVE_POINTS)) begin
      v = CURVE_MV[idx];
    end
    return v;
  endfunction

  function automatic pct_t curve_pct(input logic [SEG_W-1:0] idx);
    pct_t v;
    v = '0;
    if (idx < SEG_W'(CURVE_POINTS)) begin
      v = CURVE_PCT[idx];
    end
    return v;
  endfunction

  // microcode
  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SCALE,
    OP_ACCUM,
    OP_DIV_AVG,
    OP_MEAS,
    OP_SMOOTH,
    OP_SEG,
    OP_DIV_PCT,
    OP_PCT,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_BEAT,
    C_NOT_LAST,
    C_NO_VALID,
    C_DIV_DONE,
    C_TRIVIAL,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic            in_rdy;
    logic            hold;
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] tgt;
  } ctl_t;

  typedef struct packed {
    logic beat;
    logic last;
    logic no_valid;
    logic div_done;
    logic trivial;
    logic out_free;
  } sts_t;

  localparam logic [PC_W-1:0] ST_WAIT     = PC_W'(0);
  localparam logic [PC_W-1:0] ST_SCALE    = PC_W'(1);
  localparam logic [PC_W-1:0] ST_ACCUM    = PC_W'(2);
  localparam logic [PC_W-1:0] ST_CHECK    = PC_W'(3);
  localparam logic [PC_W-1:0] ST_AVG      = PC_W'(4);
  localparam logic [PC_W-1:0] ST_AVG_WAIT = PC_W'(5);
  localparam logic [PC_W-1:0] ST_MEAS     = PC_W'(6);
  localparam logic [PC_W-1:0] ST_SMOOTH   = PC_W'(7);
  localparam logic [PC_W-1:0] ST_SEG      = PC_W'(8);
  localparam logic [PC_W-1:0] ST_PCT_DIV  = PC_W'(9);
  localparam logic [PC_W-1:0] ST_PCT_WAIT = PC_W'(10);
  localparam logic [PC_W-1:0] ST_PCT      = PC_W'(11);
  localparam logic [PC_W-1:0] ST_EMIT     = PC_W'(12);

endpackage

>>> src/bvg_intf.sv
// Channel interfaces: reading input and gauge result output.
interface bvg_in_if;
  logic                          valid;
  logic                          ready;
  logic [bvg_pkg::ADC_BITS-1:0]  reading;
  logic                          reading_ok;
  logic                          charge_pin;

  modport source(output valid, reading, reading_ok, charge_pin, input ready);
  modport sink(input valid, reading, reading_ok, charge_pin, output ready);
endinterface

interface bvg_out_if;
  logic                       valid;
  logic                       ready;
  logic [bvg_pkg::MV_W-1:0]   battery_mv;
  logic [bvg_pkg::PCT_W-1:0]  percent;
  logic                       percent_valid;
  logic                       charging;
  logic                       updated;

  modport source(output valid, battery_mv, percent, percent_valid, charging, updated,
                 input ready);
  modport sink(input valid, battery_mv, percent, percent_valid, charging, updated,
               output ready);
endinterface

>>> src/bvg_div.sv
// Restoring divider, one quotient bit per cycle.
module bvg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bvg_pkg::SUM_W-1:0]   num_i,
  input  logic [bvg_pkg::DEN_W-1:0]   den_i,
  output logic [bvg_pkg::SUM_W-1:0]   quot_o,
  output logic                        done_o
);

  logic [bvg_pkg::DIV_STEP_W-1:0] step_q, step_d;
  logic [bvg_pkg::SUM_W-1:0]      quo_q;
  logic [bvg_pkg::DEN_W-1:0]      rem_q;
  logic [bvg_pkg::DEN_W-1:0]      den_q;
  logic [bvg_pkg::DEN_W:0]        trial;
  logic [bvg_pkg::DEN_W:0]        diff;
  logic                           fit;
  logic                           busy;

  assign busy  = (step_q != '0);
  assign trial = {rem_q, quo_q[bvg_pkg::SUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fit   = (trial >= {1'b0, den_q});

  always_comb begin
    step_d = step_q;
    if (start_i) begin
      step_d = bvg_pkg::DIV_STEP_W'(bvg_pkg::SUM_W);
    end else if (busy) begin
      step_d = step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy) begin
      rem_q <= fit ? diff[bvg_pkg::DEN_W-1:0] : trial[bvg_pkg::DEN_W-1:0];
      quo_q <= {quo_q[bvg_pkg::SUM_W-2:0], fit};
    end
  end

  assign quot_o = quo_q;
  assign done_o = !busy;

endmodule

>>> src/bvg_seq.sv
// Microcode sequencer: step counter, control ROM, conditional jumps.
module bvg_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bvg_pkg::sts_t  sts_i,
  output bvg_pkg::ctl_t  ctl_o
);

  logic [bvg_pkg::PC_W-1:0] pc_q, pc_d;
  bvg_pkg::ctl_t            word;
  logic                     take;

  function automatic bvg_pkg::ctl_t cw(input logic in_rdy, input logic hold,
                                       input bvg_pkg::op_e op, input bvg_pkg::cond_e cond,
                                       input logic [bvg_pkg::PC_W-1:0] tgt);
    bvg_pkg::ctl_t w;
    w.in_rdy = in_rdy;
    w.hold   = hold;
    w.op     = op;
    w.cond   = cond;
    w.tgt    = tgt;
    return w;
  endfunction

  function automatic bvg_pkg::ctl_t rom(input logic [bvg_pkg::PC_W-1:0] pc);
    bvg_pkg::ctl_t w;
    unique case (pc)
      bvg_pkg::ST_WAIT:
        w = cw(1'b1, 1'b1, bvg_pkg::OP_LATCH, bvg_pkg::C_BEAT, bvg_pkg::ST_SCALE);
      bvg_pkg::ST_SCALE:
        w = cw(1'b0, 1'b0, bvg_pkg::OP_SCALE, bvg_pkg::C_NEVER, bvg_pkg::ST_WAIT);
      bvg_pkg::ST_ACCUM:
        w = cw(1'b0, 1'b0, bvg_pkg::OP_ACCUM, bvg_pkg::C_NOT_LAST, bvg_pkg::ST_WAIT);
      bvg_pkg::ST_CHECK:
        w = cw(1'b0, 1'b0, bvg_pkg::OP_NONE, bvg_pkg::C_NO_VALID, bvg_pkg::ST_SEG);
      bvg_pkg::ST_AVG:
        w = cw(1'b0, 1'b0, bvg_pkg::OP_DIV_AVG, bvg_pkg::C_NEVER, bvg_pkg::ST_WAIT);
      bvg_pkg::ST_AVG_WAIT:
        w = cw(1'b0, 1'b1, bvg_pkg::OP_NONE, bvg_pkg::C_DIV_DONE, bvg_pkg::ST_MEAS);
      bvg_pkg::ST_MEAS:
        w = cw(1'b0, 1'b0, bvg_pkg::OP_MEAS, bvg_pkg::C_NEVER, bvg_pkg::ST_WAIT);
      bvg_pkg::ST_SMOOTH:
        w = cw(1'b0, 1'b0, bvg_pkg::OP_SMOOTH, bvg_pkg::C_NEVER, bvg_pkg::ST_WAIT);
      bvg_pkg::ST_SEG:
        w = cw(1'b0, 1'b0, bvg_pkg::OP_SEG, bvg_pkg::C_TRIVIAL, bvg_pkg::ST_EMIT);
      bvg_pkg::ST_PCT_DIV:
        w = cw(1'b0, 1'b0, bvg_pkg::OP_DIV_PCT, bvg_pkg::C_NEVER, bvg_pkg::ST_WAIT);
      bvg_pkg::ST_PCT_WAIT:
        w = cw(1'b0, 1'b1, bvg_pkg::OP_NONE, bvg_pkg::C_DIV_DONE, bvg_pkg::ST_PCT);
      bvg_pkg::ST_PCT:
        w = cw(1'b0, 1'b0, bvg_pkg::OP_PCT, bvg_pkg::C_NEVER, bvg_pkg::ST_WAIT);
      bvg_pkg::ST_EMIT:
        w = cw(1'b0, 1'b1, bvg_pkg::OP_EMIT, bvg_pkg::C_OUT_FREE, bvg_pkg::ST_WAIT);
      default:
        w = cw(1'b0, 1'b0, bvg_pkg::OP_NONE, bvg_pkg::C_BEAT, bvg_pkg::ST_WAIT);
    endcase
    if (pc > bvg_pkg::ST_EMIT) begin
      w.cond = bvg_pkg::C_NEVER;
      w.tgt  = bvg_pkg::ST_WAIT;
    end
    return w;
  endfunction

  assign word  = rom(pc_q);
  assign ctl_o = word;

  always_comb begin
    unique case (word.cond)
      bvg_pkg::C_NEVER:    take = 1'b0;
      bvg_pkg::C_BEAT:     take = sts_i.beat;
      bvg_pkg::C_NOT_LAST: take = !sts_i.last;
      bvg_pkg::C_NO_VALID: take = sts_i.no_valid;
      bvg_pkg::C_DIV_DONE: take = sts_i.div_done;
      bvg_pkg::C_TRIVIAL:  take = sts_i.trivial;
      bvg_pkg::C_OUT_FREE: take = sts_i.out_free;
      default:             take = 1'b0;
    endcase
  end

  always_comb begin
    priority if (take) begin
      pc_d = word.tgt;
    end else if (word.hold) begin
      pc_d = pc_q;
    end else if (pc_q >= bvg_pkg::ST_EMIT) begin
      pc_d = bvg_pkg::ST_WAIT;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= bvg_pkg::ST_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> src/bvg_dp.sv
// Datapath: reading scaling, burst accumulation, smoothing, curve lookup, result register.
module bvg_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bvg_pkg::ctl_t                     ctl_i,
  output bvg_pkg::sts_t                     sts_o,
  bvg_in_if.sink                            in_i,
  bvg_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [bvg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bvg_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int RW = bvg_pkg::PROD_W + 1;

  // config
  logic                          raw_q;
  logic [bvg_pkg::RATIO_W-1:0]   ratio_q;

  // item
  logic [bvg_pkg::ADC_BITS-1:0]  reading_q;
  logic                          ok_q;
  logic                          pin_q;
  logic [bvg_pkg::PROD_W-1:0]    prod_q;

  // burst / gauge state
  logic [bvg_pkg::SUM_W-1:0]     sum_q;
  logic [bvg_pkg::CNT_W-1:0]     cnt_q;
  logic [bvg_pkg::CNT_W-1:0]     idx_q;
  bvg_pkg::mv_t                  smooth_q;
  logic                          chg_q;
  logic                          upd_q;
  bvg_pkg::mv_t                  meas_q;
  logic [bvg_pkg::SUM_W-1:0]     num_q;
  logic [bvg_pkg::DEN_W-1:0]     den_q;
  bvg_pkg::pct_t                 base_q;
  bvg_pkg::pct_t                 pct_q;

  // result register
  logic                          out_valid_q;
  bvg_pkg::mv_t                  out_mv_q;
  bvg_pkg::pct_t                 out_pct_q;
  logic                          out_pv_q;
  logic                          out_chg_q;
  logic                          out_upd_q;

  logic                          beat;
  logic                          last;
  logic                          out_free;
  logic                          do_emit;

  logic [bvg_pkg::QE_W-1:0]      qe;
  logic [RW-1:0]                 rem;
  logic [bvg_pkg::QE_W-1:0]      q_fix;
  logic [bvg_pkg::PIN_MV_W-1:0]  pin_mv;

  logic [bvg_pkg::MEAS_W-1:0]    meas_full;
  bvg_pkg::mv_t                  meas_sat;
  logic [bvg_pkg::MV_W+1:0]      blend;
  bvg_pkg::mv_t                  smooth_d;

  logic [bvg_pkg::SEG_W-1:0]     seg;
  logic [bvg_pkg::SEG_W-1:0]     seg_lo;
  bvg_pkg::mv_t                  lo_mv;
  bvg_pkg::mv_t                  dv;
  bvg_pkg::pct_t                 dp;
  bvg_pkg::mv_t                  off;
  logic                          is_top;
  logic                          trivial;

  logic                          div_start;
  logic [bvg_pkg::SUM_W-1:0]     div_num;
  logic [bvg_pkg::DEN_W-1:0]     div_den;
  logic [bvg_pkg::SUM_W-1:0]     div_quot;
  logic                          div_done;

  assign in_i.ready = ctl_i.in_rdy;
  assign beat       = in_i.valid && ctl_i.in_rdy;
  assign last       = (idx_q == bvg_pkg::CNT_W'(bvg_pkg::SAMPLES_PER_UPDATE - 1));
  assign out_free   = !out_valid_q || out_o.ready;
  assign do_emit    = (ctl_i.op == bvg_pkg::OP_EMIT) && out_free;

  // reading * 3100 / ADC_FULL: series estimate, then up to two corrections
  always_comb begin
    qe    = bvg_pkg::QE_W'((RW'(prod_q) + RW'(prod_q >> bvg_pkg::ADC_BITS))
                           >> bvg_pkg::ADC_BITS);
    rem   = RW'(prod_q) + RW'(qe) - (RW'(qe) << bvg_pkg::ADC_BITS);
    q_fix = qe + bvg_pkg::QE_W'(rem >= RW'(bvg_pkg::ADC_FULL))
               + bvg_pkg::QE_W'(rem >= RW'(2 * bvg_pkg::ADC_FULL));
    pin_mv = raw_q ? bvg_pkg::PIN_MV_W'(q_fix) : bvg_pkg::PIN_MV_W'(reading_q);
  end

  always_comb begin
    meas_full = bvg_pkg::MEAS_W'(div_quot) * bvg_pkg::MEAS_W'(ratio_q);
    meas_sat  = (meas_full > bvg_pkg::MEAS_W'(bvg_pkg::MV_MAX))
              ? bvg_pkg::mv_t'(bvg_pkg::MV_MAX) : meas_full[bvg_pkg::MV_W-1:0];
    blend     = ({2'b00, smooth_q} << 1) + {2'b00, smooth_q} + {2'b00, meas_q};
    smooth_d  = (smooth_q == '0) ? meas_q : blend[bvg_pkg::MV_W+1:2];
  end

  // curve segment: highest point index whose voltage is at or above the sample
  always_comb begin
    seg = '0;
    for (int j = 1; j < bvg_pkg::CURVE_POINTS; j++) begin
      if (smooth_q <= bvg_pkg::CURVE_MV[j]) begin
        seg = bvg_pkg::SEG_W'(j);
      end
    end
    seg_lo  = seg + 1'b1;
    lo_mv   = bvg_pkg::curve_mv(seg_lo);
    dv      = bvg_pkg::curve_mv(seg) - lo_mv;
    dp      = bvg_pkg::curve_pct(seg) - bvg_pkg::curve_pct(seg_lo);
    off     = smooth_q - lo_mv;
    is_top  = (smooth_q >= bvg_pkg::CURVE_MV[0]);
    trivial = (smooth_q == '0) || is_top
           || (smooth_q <= bvg_pkg::CURVE_MV[bvg_pkg::CURVE_POINTS-1]);
  end

  always_comb begin
    div_start = (ctl_i.op == bvg_pkg::OP_DIV_AVG) || (ctl_i.op == bvg_pkg::OP_DIV_PCT);
    if (ctl_i.op == bvg_pkg::OP_DIV_AVG) begin
      div_num = sum_q;
      div_den = bvg_pkg::DEN_W'(cnt_q);
    end else begin
      div_num = num_q;
      div_den = den_q;
    end
  end

  bvg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  assign sts_o.beat     = beat;
  assign sts_o.last     = last;
  assign sts_o.no_valid = (cnt_q == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.trivial  = trivial;
  assign sts_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q   <= 1'b0;
      ratio_q <= bvg_pkg::RATIO_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bvg_pkg::CFG_RAW_MODE:      raw_q   <= cfg_data_i[0];
        bvg_pkg::CFG_DIVIDER_RATIO: ratio_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      smooth_q    <= '0;
      chg_q       <= 1'b0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.op == bvg_pkg::OP_ACCUM) begin
        if (ok_q) begin
          sum_q <= sum_q + bvg_pkg::SUM_W'(pin_mv);
          cnt_q <= cnt_q + 1'b1;
        end
        idx_q <= last ? '0 : idx_q + 1'b1;
      end
      if (ctl_i.op == bvg_pkg::OP_SMOOTH) begin
        smooth_q <= smooth_d;
        chg_q    <= !pin_q;
        upd_q    <= 1'b1;
      end
      if (do_emit) begin
        sum_q <= '0;
        cnt_q <= '0;
        upd_q <= 1'b0;
      end
      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      bvg_pkg::OP_LATCH: begin
        if (beat) begin
          reading_q <= in_i.reading;
          ok_q      <= in_i.reading_ok;
          pin_q     <= in_i.charge_pin;
        end
      end
      bvg_pkg::OP_SCALE: begin
        prod_q <= bvg_pkg::PROD_W'(reading_q) * bvg_pkg::PROD_W'(bvg_pkg::PIN_FULL_MV);
      end
      bvg_pkg::OP_MEAS: begin
        meas_q <= meas_sat;
      end
      bvg_pkg::OP_SEG: begin
        num_q  <= bvg_pkg::SUM_W'(off[bvg_pkg::DEN_W-1:0] * dp);
        den_q  <= dv[bvg_pkg::DEN_W-1:0];
        base_q <= bvg_pkg::curve_pct(seg_lo);
        pct_q  <= is_top ? bvg_pkg::CURVE_PCT[0] : '0;
      end
      bvg_pkg::OP_PCT: begin
        pct_q <= base_q + div_quot[bvg_pkg::PCT_W-1:0];
      end
      default: ;
    endcase
    if (do_emit) begin
      out_mv_q  <= smooth_q;
      out_pct_q <= (smooth_q == '0) ? '0 : pct_q;
      out_pv_q  <= (smooth_q != '0);
      out_chg_q <= chg_q;
      out_upd_q <= upd_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.battery_mv    = out_mv_q;
  assign out_o.percent       = out_pct_q;
  assign out_o.percent_valid = out_pv_q;
  assign out_o.charging      = out_chg_q;
  assign out_o.updated       = out_upd_q;

endmodule

>>> src/battery_voltage_gauge_top.sv
// Top level of the battery voltage gauge.
// Readings come in bursts of eight; a reading beat runs through the latch, scale and
// accumulate steps, and only the last beat of a burst yields a result. Burst end runs
// through a microcoded step program that uses one 16-step restoring divider up to
// twice, once for the average and once for the curve interpolation; the average
// divide is skipped when no reading was valid, and the interpolation divide when the
// voltage is zero or at or outside the curve ends. The result register frees the
// input side as soon as it is loaded; a new result waits only while the previous
// one has not been taken.
module battery_voltage_gauge_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bvg_in_if.sink                            in_i,
  bvg_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [bvg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bvg_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  bvg_pkg::ctl_t ctl;
  bvg_pkg::sts_t sts;

  bvg_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  bvg_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .in_i       (in_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule
